@@ hw/rtl/dtws_pkg.sv @@
`default_nettype none

package dtws_pkg;

  // Table geometry and phase format (10.16 table positions)
  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned TBL_IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PHASE_W    = TBL_IDX_W + FRAC_W;

  // Field widths
  localparam int unsigned STEP_W  = 26;
  localparam int unsigned VOL_W   = 12;
  localparam int unsigned DAC_W   = 12;
  localparam int unsigned SINE_W  = 16;
  localparam int unsigned MIX_W   = SINE_W + 1;
  localparam int unsigned PROD_W  = MIX_W + VOL_W + 1;

  // Output scaling
  localparam int unsigned MIX_SHIFT = 17;
  localparam int unsigned DAC_MID   = 2048;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE0_STEP = 2'd0,
    REG_TONE1_STEP = 2'd1
  } cfg_reg_e;

  // Sine table build constants (Q2.30)
  localparam logic [63:0] PIH_Q30  = 64'd1686629713;
  localparam logic [63:0] Q30_HALF = 64'd536870912;
  localparam int unsigned SINE_MAX = 32767;

  typedef logic [63:0] taylor_div_t [8];
  localparam taylor_div_t TAYLOR_DIV = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  typedef logic signed [SINE_W-1:0] sine_rom_t [TABLE_SIZE];

  // First quarter of the sine wave, r in table steps of a quarter period
  function automatic logic signed [SINE_W-1:0] quarter_sine(int unsigned r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    if (r == 0) begin
      return '0;
    end
    if (r >= TABLE_SIZE) begin
      return SINE_W'(SINE_MAX);
    end
    x    = (PIH_Q30 * 64'(r) + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
    x2   = (x * x + Q30_HALF) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 0; k < 8; k++) begin
      term = ((term * x2 + Q30_HALF) >> 30) / TAYLOR_DIV[k];
      if (k[0] == 1'b0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = (unsigned'(sum) * 64'(SINE_MAX)) >> 30;
    if (v > 64'(SINE_MAX)) begin
      v = 64'(SINE_MAX);
    end
    return SINE_W'(v);
  endfunction

  // Full-period table from quarter-wave symmetry
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    int unsigned q;
    int unsigned r;
    for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
      q = (4 * i) / TABLE_SIZE;
      r = (4 * i) % TABLE_SIZE;
      case (q)
        0:       rom[i] = quarter_sine(r);
        1:       rom[i] = quarter_sine(TABLE_SIZE - r);
        2:       rom[i] = -quarter_sine(r);
        default: rom[i] = -quarter_sine(TABLE_SIZE - r);
      endcase
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dual_tone_wavetable_synth.sv @@
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    volume_level_i  [11:0]
// out       output     out_valid_o / out_stall_i  dac_code_o      [11:0]
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i [25:0]
//
// One request per cycle is sustained while out_stall_i is low. Stages: phase
// add and registered sine ROM read, then the tone sum and volume multiply,
// then shift/offset into the output register.
// Reset clears both phases, both step registers and all stage valids.
// A stall on the output backs up stage by stage; empty stages still fill.
// cfg_ready_o is always high; a zero step also clears that channel's phase.
`default_nettype none

module dual_tone_wavetable_synth
  import dtws_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [VOL_W-1:0]     volume_level_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [DAC_W-1:0]          dac_code_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [STEP_W-1:0]    cfg_data_i
);

  localparam sine_rom_t SineRom = build_sine_rom();

  logic [STEP_W-1:0]  step0_q, step1_q;
  logic [PHASE_W-1:0] phase0_q, phase1_q;
  logic [PHASE_W-1:0] phase0_nxt, phase1_nxt;
  logic               cfg_wr, wr0, wr1, in_acc;

  // Stage valids and per-stage advance
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic signed [SINE_W-1:0] rom0_q, rom1_q;
  logic [VOL_W-1:0]         vol1_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MIX_W-1:0]  mix;
  logic signed [PROD_W-1:0] prod_d;
  logic [DAC_W-1:0]         dac_q;
  logic [DAC_W-1:0]         dac_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign wr0         = cfg_wr && (cfg_index_i == REG_TONE0_STEP);
  assign wr1         = cfg_wr && (cfg_index_i == REG_TONE1_STEP);

  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Phase accumulators wrap at the table length (a power of two)
  assign phase0_nxt = phase0_q + PHASE_W'(step0_q);
  assign phase1_nxt = phase1_q + PHASE_W'(step1_q);

  // Step registers and phases; a zero step write clears the phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step0_q  <= '0;
      step1_q  <= '0;
      phase0_q <= '0;
      phase1_q <= '0;
    end else begin
      if (wr0) begin
        step0_q <= cfg_data_i;
      end
      if (wr1) begin
        step1_q <= cfg_data_i;
      end
      if (wr0 && (cfg_data_i == '0)) begin
        phase0_q <= '0;
      end else if (in_acc) begin
        phase0_q <= phase0_nxt;
      end
      if (wr1 && (cfg_data_i == '0)) begin
        phase1_q <= '0;
      end else if (in_acc) begin
        phase1_q <= phase1_nxt;
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_acc;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage 1: registered ROM reads at the new phases
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rom0_q <= SineRom[phase0_nxt[PHASE_W-1 -: TBL_IDX_W]];
      rom1_q <= SineRom[phase1_nxt[PHASE_W-1 -: TBL_IDX_W]];
      vol1_q <= volume_level_i;
    end
  end

  // Stage 2: mix and scale by volume, both operands at full product width
  assign mix    = MIX_W'(rom0_q) + MIX_W'(rom1_q);
  assign prod_d = PROD_W'(mix) * PROD_W'($signed({1'b0, vol1_q}));

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      prod_q <= prod_d;
    end
  end

  // Stage 3: floor shift and recenter
  assign dac_d = DAC_W'(prod_q >>> MIX_SHIFT) + DAC_W'(DAC_MID);

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      dac_q <= dac_d;
    end
  end

  assign out_valid_o = v3_q;
  assign dac_code_o  = dac_q;

`ifndef SYNTHESIS
  a_phase0_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr0 && (cfg_data_i == '0) |=> phase0_q == '0)
    else $error("phase0 not cleared by zero step");

  a_phase1_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr1 && (cfg_data_i == '0) |=> phase1_q == '0)
    else $error("phase1 not cleared by zero step");

  a_step_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr0 |=> step0_q == $past(cfg_data_i))
    else $error("tone0 step write lost");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q)
    else $error("accepted request not in stage 1");

  a_hold_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy3 |=> v2_q && v3_q)
    else $error("stage 2 item dropped under stall");
`endif

endmodule

`default_nettype wire

@@ tb/sv/dual_tone_wavetable_synth_test.sv @@
`default_nettype none

module dual_tone_wavetable_synth_test
  import dtws_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Pipeline depth, used for settling and the end wait
  localparam int PIPE_LATENCY   = 3;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BURST   = 100;
  localparam int HOLD_BURST     = 40;

  // Register indexes outside the map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

  // Step values with a known meaning in table positions
  localparam logic [STEP_W-1:0] ONE_ENTRY    = STEP_W'(1) << FRAC_W;
  localparam logic [STEP_W-1:0] QUARTER_TURN = STEP_W'(TABLE_SIZE / 4) << FRAC_W;
  localparam logic [STEP_W-1:0] STEP_MAX     = '1;
  localparam logic [63:0]       PHASE_WRAP   = 64'(TABLE_SIZE) << FRAC_W;

  // Fixed-point constants for the quarter-wave series (Q2.30)
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ROUND_Q30   = 64'd1 << 29;
  localparam int          PEAK_LEVEL  = 32767;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [VOL_W-1:0]     volume_level_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [DAC_W-1:0]     dac_code_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [STEP_W-1:0]    cfg_data_i;

  dual_tone_wavetable_synth uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .volume_level_i (volume_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dac_code_o     (dac_code_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Predictor state: own copy of steps, phases and the sine table
  logic signed [SINE_W-1:0] sine_table [TABLE_SIZE];
  logic [STEP_W-1:0]        step0;
  logic [STEP_W-1:0]        step1;
  logic [63:0]              phase0;
  logic [63:0]              phase1;

  logic [DAC_W-1:0] expected_codes [$];

  int  send_idle_pct;
  int  stall_pct;
  bit  hold_request;
  int  fail_count;
  int  samples_checked;
  int  requests_sent;
  int  reg_writes;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sine of r quarter-period steps, truncated series in Q2.30
  function automatic int quarter_wave(int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    longint      lvl;
    if (r == 0) begin
      return 0;
    end
    if (r >= TABLE_SIZE) begin
      return PEAK_LEVEL;
    end
    x    = (HALF_PI_Q30 * 64'(r) + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
    x2   = (x * x + ROUND_Q30) >> 30;
    term = x;
    acc  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2 + ROUND_Q30) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    lvl = (acc * PEAK_LEVEL) >> 30;
    if (lvl > PEAK_LEVEL) begin
      lvl = PEAK_LEVEL;
    end
    return int'(lvl);
  endfunction

  // Advance both phases by one tick and mix the two tones at this volume
  function automatic logic [DAC_W-1:0] mix_next_sample(logic [VOL_W-1:0] vol);
    int lvl0;
    int lvl1;
    int scaled;
    phase0 = (phase0 + 64'(step0)) % PHASE_WRAP;
    phase1 = (phase1 + 64'(step1)) % PHASE_WRAP;
    lvl0   = sine_table[int'((phase0 >> FRAC_W) % TABLE_SIZE)];
    lvl1   = sine_table[int'((phase1 >> FRAC_W) % TABLE_SIZE)];
    // arithmetic shift floors negative mixes
    scaled = ((lvl0 + lvl1) * int'(vol)) >>> MIX_SHIFT;
    return DAC_W'(scaled + int'(DAC_MID));
  endfunction

  function automatic logic [STEP_W-1:0] random_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return STEP_MAX;
      2:       return STEP_W'(ONE_ENTRY * $urandom_range(1, TABLE_SIZE - 1));
      3:       return STEP_W'($urandom_range(1, 4095));
      default: return STEP_W'($urandom);
    endcase
  endfunction

  function automatic logic [VOL_W-1:0] random_volume();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return VOL_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // Offer one volume request, with random idle cycles ahead of it
  task automatic send_volume(input logic [VOL_W-1:0] vol);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i     <= 1'b0;
      volume_level_i <= VOL_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    volume_level_i <= vol;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_codes.push_back(mix_next_sample(vol));
    requests_sent++;
  endtask

  // Drop the request line and wait until every sample has come out
  task automatic settle_output();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 1) @(negedge clk_i);
  endtask

  // Register write; only called with the datapath idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_TONE0_STEP: begin
        step0 = data;
        if (data == '0) phase0 = '0;
      end
      REG_TONE1_STEP: begin
        step1 = data;
        if (data == '0) phase1 = '0;
      end
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_IDX_W'($urandom);
    cfg_data_i  <= STEP_W'($urandom);
  endtask

  // Both steps are zero out of reset: silence at any volume
  task automatic test_reset_silence();
    send_volume('0);
    send_volume('1);
    send_volume(12'hAAA);
    send_volume(12'h555);
    settle_output();
  endtask

  // Quarter-turn steps walk the table peaks: full scale, zero, floor of negative mix
  task automatic test_table_extremes();
    write_reg(REG_TONE0_STEP, QUARTER_TURN);
    write_reg(REG_TONE1_STEP, QUARTER_TURN);
    send_volume('1);
    send_volume('1);
    send_volume('1);
    send_volume(12'd1);
    send_volume('1);
    send_volume(12'd2048);
    send_volume(12'd1);
    settle_output();
    // largest step wraps the phase every tick
    write_reg(REG_TONE0_STEP, STEP_MAX);
    write_reg(REG_TONE1_STEP, ONE_ENTRY);
    repeat (3) send_volume(random_volume());
    settle_output();
  endtask

  // A zero step also clears that channel's phase
  task automatic test_zero_step_clear();
    write_reg(REG_TONE0_STEP, '0);
    write_reg(REG_TONE1_STEP, '0);
    send_volume('1);
    send_volume(12'h7FF);
    settle_output();
    write_reg(REG_TONE0_STEP, STEP_W'(3 * ONE_ENTRY + 12345));
    repeat (3) send_volume(random_volume());
    settle_output();
  endtask

  // Writes to indexes outside the map leave both steps alone
  task automatic test_unmapped_index();
    write_reg(REG_UNMAPPED_LO, STEP_W'($urandom));
    write_reg(REG_UNMAPPED_HI, STEP_MAX);
    repeat (3) send_volume(random_volume());
    settle_output();
  endtask

  // Random steps and volumes under each idle/stall mix
  task automatic test_random_traffic();
    int idle_mix [4];
    int stall_mix [4];
    idle_mix  = '{0, 63, 0, 38};
    stall_mix = '{0, 0, 63, 38};
    for (int m = 0; m < 4; m++) begin
      for (int rep = 0; rep < 2; rep++) begin
        send_idle_pct = idle_mix[m];
        stall_pct     = stall_mix[m];
        write_reg(REG_TONE0_STEP, random_step());
        write_reg(REG_TONE1_STEP, random_step());
        if ($urandom_range(0, 3) == 0) begin
          write_reg(REG_UNMAPPED_LO + CFG_IDX_W'($urandom_range(0, 1)), random_step());
        end
        repeat (RANDOM_BURST) send_volume(random_volume());
        settle_output();
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // Long output hold-off while requests keep coming: pipeline fills and backs up
  task automatic test_output_holdoff();
    write_reg(REG_TONE0_STEP, random_step());
    write_reg(REG_TONE1_STEP, random_step());
    hold_request = 1'b1;
    repeat (HOLD_BURST) send_volume(random_volume());
    settle_output();
  endtask

  // Output stall driver: random stalls, or one long hold on request
  initial begin : output_stall
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Compare each accepted sample with the oldest prediction
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected sample, expected none, got dac_code %0d",
                 $time, dac_code_o);
        fail_count++;
      end else begin
        if (dac_code_o !== expected_codes[0]) begin
          $display("%0t: dac_code mismatch, expected %0d, got %0d",
                   $time, expected_codes[0], dac_code_o);
          fail_count++;
        end
        void'(expected_codes.pop_front());
        samples_checked++;
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no handshake at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0) ||
          (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: timeout, no request accepted for %0d cycles", $time, quiet);
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    volume_level_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_TONE0_STEP;
    cfg_data_i      = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    hold_request    = 1'b0;
    fail_count      = 0;
    samples_checked = 0;
    requests_sent   = 0;
    reg_writes      = 0;
    step0           = '0;
    step1           = '0;
    phase0          = '0;
    phase1          = '0;

    // quarter-wave symmetry fills the full period
    for (int i = 0; i < TABLE_SIZE; i++) begin
      case ((4 * i) / TABLE_SIZE)
        0:       sine_table[i] = SINE_W'(quarter_wave((4 * i) % TABLE_SIZE));
        1:       sine_table[i] = SINE_W'(quarter_wave(TABLE_SIZE - (4 * i) % TABLE_SIZE));
        2:       sine_table[i] = SINE_W'(-quarter_wave((4 * i) % TABLE_SIZE));
        default: sine_table[i] = SINE_W'(-quarter_wave(TABLE_SIZE - (4 * i) % TABLE_SIZE));
      endcase
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_silence();
    test_table_extremes();
    test_zero_step_clear();
    test_unmapped_index();
    test_random_traffic();
    test_output_holdoff();

    settle_output();
    repeat (4 * PIPE_LATENCY) @(posedge clk_i);
    fail_count += expected_codes.size();

    $display("Checked %0d samples from %0d volume requests and %0d register writes,",
             samples_checked, requests_sent, reg_writes);
    $display("across table peaks, zero-step clears, unmapped writes, idle/stall mixes and a long hold-off.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
